@@ hdl/ttsched_pkg.sv @@
// shared types, constants and helpers for the timer table scheduler
// no dependencies; imported by ttsched_cell and timer_table_scheduler_core
package ttsched_pkg;

  localparam int TimerSlots = 16;
  localparam int IdxW = (TimerSlots > 1) ? $clog2(TimerSlots) : 1;
  localparam int CntW = $clog2(TimerSlots + 1);
  localparam logic [31:0] TimeMax = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CmdOneShot  = 2'd0,
    CmdPeriodic = 2'd1,
    CmdCancel   = 2'd2,
    CmdTick     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDone
  } state_e;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] due;
    logic [31:0] interval;
  } entry_t;

  // per-cycle control broadcast to every cell of the row
  typedef struct packed {
    logic            shift_en;
    logic            ins_en;
    logic [IdxW-1:0] ins_pos;
  } cell_ctrl_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? TimeMax : s[31:0];
  endfunction

endpackage

@@ hdl/ttsched_cell.sv @@
// one slot of the timer row: holds one entry, loads it from the right-hand
// neighbor on a shift or from the insert bus; depends on ttsched_pkg
module ttsched_cell import ttsched_pkg::*; (
  input  logic            clk_i,
  input  logic [IdxW-1:0] cell_idx_i,
  input  cell_ctrl_t      ctrl_i,
  input  entry_t          ins_data_i,
  input  entry_t          right_i,
  output entry_t          entry_o
);

  entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins_en && (ctrl_i.ins_pos == cell_idx_i)) begin
      entry_d = ins_data_i;
    end else if (ctrl_i.shift_en && (!ctrl_i.ins_en || (cell_idx_i < ctrl_i.ins_pos))) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

@@ hdl/timer_table_scheduler_core.sv @@
// timer table scheduler: ordered list of one-shot and periodic timers kept
// in a row of shifting cells; depends on ttsched_pkg and ttsched_cell
// schedule: never busy, ack item on the result ports the cycle after start
// cancel, tick: busy while the list is scanned, one pop per timer, then done;
//   the next item is taken only once the block is back in idle
// fired items: at most one per cycle, each shown the cycle after the head pops the next
//   due timer; the final one, with last, shows the cycle after done
// reset (rst_ni low, async) empties the list, id counter to 1, time to 0,
// min_interval to 1; results are strobes and cannot be stalled by the receiver
module timer_table_scheduler_core import ttsched_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] delay_ms_i,
  input  logic [31:0] timer_id_i,
  input  logic [31:0] now_ms_i,
  input  logic        min_interval_we_i,
  input  logic [15:0] min_interval_i,
  output logic        result_valid_o,
  output logic        kind_o,
  output logic [31:0] out_id_o,
  output logic        periodic_o,
  output logic        last_o
);

  state_e state_q, state_d;

  // control registers
  logic [15:0]     min_interval_q;
  logic [CntW-1:0] n_q, n_d;      // timers held, always a prefix of the row
  logic [CntW-1:0] u_q, u_d;      // entries still to pop this round
  logic [CntW-1:0] k_q, k_d;      // entries kept this round
  logic [CntW-1:0] m_q, m_d;      // periodic entries re-armed this round
  logic            found_q, found_d;
  logic [31:0]     next_id_q, next_id_d;
  logic [31:0]     last_now_q, last_now_d;
  cmd_e            cmd_q, cmd_d;
  logic [31:0]     arg_q, arg_d;  // cancel id or tick time

  // one fired item held back so the final one can carry last
  logic            pend_valid_q, pend_valid_d;
  logic [31:0]     pend_id_q, pend_id_d;
  logic            pend_per_q, pend_per_d;

  // result register
  logic            out_valid_q, out_valid_d;
  logic            out_kind_q, out_kind_d;
  logic [31:0]     out_id_q, out_id_d;
  logic            out_per_q, out_per_d;
  logic            out_last_q, out_last_d;

  cell_ctrl_t      ctrl;
  entry_t          ins_data;
  entry_t          cells [TimerSlots];

  logic            accept;
  cmd_e            cmd_in;
  entry_t          head;
  logic [CntW-1:0] base;
  logic [CntW-1:0] rearm_pos;
  logic [31:0]     period;
  logic [31:0]     sched_due;
  logic [31:0]     id_inc;

  assign busy   = (state_q != StIdle);
  assign accept = start && !busy;
  assign cmd_in = cmd_e'(cmd_i);
  assign head   = cells[0];

  // row of cells, each handing its entry to the left neighbor on a shift
  for (genvar j = 0; j < TimerSlots; j++) begin : g_cell
    entry_t right;
    if (j == TimerSlots - 1) begin : g_end
      assign right = cells[j];
    end else begin : g_mid
      assign right = cells[j+1];
    end
    ttsched_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (IdxW'(j)),
      .ctrl_i     (ctrl),
      .ins_data_i (ins_data),
      .right_i    (right),
      .entry_o    (cells[j])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept && ((cmd_in == CmdCancel) || (cmd_in == CmdTick))) begin
          state_d = (n_q == '0) ? StDone : StScan;
        end
      end
      StScan: begin
        if (u_q == CntW'(1)) state_d = StDone;
      end
      StDone:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // schedule arithmetic
  always_comb begin
    if (cmd_in == CmdPeriodic) begin
      period = (delay_ms_i > {16'b0, min_interval_q}) ? delay_ms_i : {16'b0, min_interval_q};
    end else begin
      period = '0;
    end
    sched_due = sat_add(last_now_q, (cmd_in == CmdPeriodic) ? period : delay_ms_i);
    id_inc    = next_id_q + 32'd1;
  end

  // popped head goes back in after the unpopped and kept entries;
  // re-armed periodic ones go after those
  assign base      = u_q - CntW'(1) + k_q;
  assign rearm_pos = base + m_q;

  // datapath and outputs
  always_comb begin
    ctrl         = '0;
    ins_data     = head;
    n_d          = n_q;
    u_d          = u_q;
    k_d          = k_q;
    m_d          = m_q;
    found_d      = found_q;
    next_id_d    = next_id_q;
    last_now_d   = last_now_q;
    cmd_d        = cmd_q;
    arg_d        = arg_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    pend_per_d   = pend_per_q;
    out_valid_d  = 1'b0;
    out_kind_d   = out_kind_q;
    out_id_d     = out_id_q;
    out_per_d    = out_per_q;
    out_last_d   = out_last_q;

    case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_d = cmd_in;
          u_d   = n_q;
          k_d   = '0;
          m_d   = '0;
          found_d = 1'b0;
          case (cmd_in)
            CmdOneShot, CmdPeriodic: begin
              out_valid_d = 1'b1;
              out_kind_d  = 1'b0;
              out_per_d   = 1'b0;
              out_last_d  = 1'b1;
              if (n_q < CntW'(TimerSlots)) begin
                ctrl.ins_en  = 1'b1;
                ctrl.ins_pos = n_q[IdxW-1:0];
                ins_data     = '{id: next_id_q, due: sched_due, interval: period};
                n_d          = n_q + CntW'(1);
                out_id_d     = next_id_q;
                // id zero is reserved for the table-full ack
                next_id_d    = (id_inc == '0) ? 32'd1 : id_inc;
              end else begin
                out_id_d = '0;
              end
            end
            CmdCancel: arg_d = timer_id_i;
            CmdTick: begin
              arg_d      = now_ms_i;
              last_now_d = now_ms_i;
            end
            default: ;
          endcase
        end
      end

      StScan: begin
        ctrl.shift_en = 1'b1;
        u_d = u_q - CntW'(1);
        if (cmd_q == CmdTick) begin
          if (head.due <= arg_q) begin
            // timer fires: emit the held item, hold this one
            pend_valid_d = 1'b1;
            pend_id_d    = head.id;
            pend_per_d   = (head.interval != '0);
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_kind_d  = 1'b1;
              out_id_d    = pend_id_q;
              out_per_d   = pend_per_q;
              out_last_d  = 1'b0;
            end
            if (head.interval != '0) begin
              ctrl.ins_en  = 1'b1;
              ctrl.ins_pos = rearm_pos[IdxW-1:0];
              ins_data.due = sat_add(arg_q, head.interval);
              m_d          = m_q + CntW'(1);
            end
          end else begin
            ctrl.ins_en  = 1'b1;
            ctrl.ins_pos = base[IdxW-1:0];
            k_d          = k_q + CntW'(1);
          end
        end else begin
          // cancel drops only the first match
          if (!found_q && (head.id == arg_q)) begin
            found_d = 1'b1;
          end else begin
            ctrl.ins_en  = 1'b1;
            ctrl.ins_pos = base[IdxW-1:0];
            k_d          = k_q + CntW'(1);
          end
        end
      end

      StDone: begin
        n_d = k_q + m_q;
        if (pend_valid_q) begin
          out_valid_d  = 1'b1;
          out_kind_d   = 1'b1;
          out_id_d     = pend_id_q;
          out_per_d    = pend_per_q;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      min_interval_q <= 16'd1;
      n_q            <= '0;
      u_q            <= '0;
      k_q            <= '0;
      m_q            <= '0;
      found_q        <= 1'b0;
      next_id_q      <= 32'd1;
      last_now_q     <= '0;
      cmd_q          <= CmdOneShot;
      pend_valid_q   <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      if (min_interval_we_i) min_interval_q <= min_interval_i;
      n_q          <= n_d;
      u_q          <= u_d;
      k_q          <= k_d;
      m_q          <= m_d;
      found_q      <= found_d;
      next_id_q    <= next_id_d;
      last_now_q   <= last_now_d;
      cmd_q        <= cmd_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    arg_q      <= arg_d;
    pend_id_q  <= pend_id_d;
    pend_per_q <= pend_per_d;
    out_kind_q <= out_kind_d;
    out_id_q   <= out_id_d;
    out_per_q  <= out_per_d;
    out_last_q <= out_last_d;
  end

  assign result_valid_o = out_valid_q;
  assign kind_o         = out_kind_q;
  assign out_id_o       = out_id_q;
  assign periodic_o     = out_per_q;
  assign last_o         = out_last_q;

  // an ack is always the only item of its command
  a_ack_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_kind_q) |-> out_last_q)
    else $error("ack item without last");

  // the row never holds more timers than it has cells
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CntW'(TimerSlots))
    else $error("fill count beyond row size");

  // a held fired item never survives into idle
  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !pend_valid_q)
    else $error("fired item left pending");

  // a round never grows the list
  a_round_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> ((u_q + k_q + m_q) <= n_q))
    else $error("round bookkeeping exceeds fill count");

endmodule
